// ===== hdl/seq_pkg.sv =====
// Shared types and constants for the sorted event queue.
package seq_pkg;

    localparam int SEQ_DEPTH    = 16;
    localparam int HANDLE_SLOTS = 16;
    localparam int HANDLE_W     = 4;
    localparam int TAG_W        = 32;
    localparam int TIME_W       = 64;
    localparam int COUNT_W      = 5;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_POP    = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_CLEAR  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOHANDLE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_REMOVE,
        OP_CLEAR
    } t_op;

    typedef enum logic {
        FSM_IDLE,
        FSM_EXEC
    } t_fsm;

    typedef struct packed {
        logic                valid;
        logic [TIME_W-1:0]   ev_time;
        logic [TAG_W-1:0]    tag;
        logic [HANDLE_W-1:0] handle;
    } t_slot;

    typedef struct packed {
        t_op                 op;
        logic [TIME_W-1:0]   ev_time;
        logic [TAG_W-1:0]    tag;
        logic [HANDLE_W-1:0] handle;
        logic [HANDLE_W-1:0] target;
    } t_cell_cmd;

endpackage

// ===== hdl/seq_cell.sv =====
// One storage cell of the sorted chain: holds a single entry and shifts with its neighbors.
module seq_cell import seq_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_cmd i_cmd,
    input  t_slot     i_left,
    input  logic      i_left_m,
    input  logic      i_left_d,
    input  t_slot     i_right,
    output t_slot     o_slot,
    output t_slot     o_next,
    output logic      o_m,
    output logic      o_d,
    output logic      o_hit
);

    logic                r_valid;
    logic [TIME_W-1:0]   r_time;
    logic [TAG_W-1:0]    r_tag;
    logic [HANDLE_W-1:0] r_handle;
    t_slot               n_slot;

    assign o_slot = '{valid: r_valid, ev_time: r_time, tag: r_tag, handle: r_handle};

    // An empty cell or one with a later time marks where an insert lands.
    assign o_m   = !r_valid || (r_time > i_cmd.ev_time);
    assign o_hit = r_valid && (r_handle == i_cmd.target);
    assign o_d   = o_hit || i_left_d;

    always_comb begin
        n_slot = o_slot;
        unique case (i_cmd.op)
            OP_HOLD: begin
            end
            OP_INSERT: begin
                if (i_left_m) begin
                    n_slot = i_left;
                end else if (o_m) begin
                    n_slot = '{valid: 1'b1, ev_time: i_cmd.ev_time, tag: i_cmd.tag,
                               handle: i_cmd.handle};
                end
            end
            OP_REMOVE: begin
                if (o_d) begin
                    n_slot = i_right;
                end
            end
            OP_CLEAR: begin
                n_slot.valid = 1'b0;
            end
            default: begin
            end
        endcase
    end

    assign o_next = n_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_slot.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_time   <= n_slot.ev_time;
        r_tag    <= n_slot.tag;
        r_handle <= n_slot.handle;
    end

endmodule

// ===== hdl/sorted_event_queue.sv =====
// Top level of the sorted event queue: request control, handle pool and cell chain.
//
//  channel | valid   | stall   | fields
//  request | i_valid | o_stall | i_req_type i_event_tag i_event_time i_target_handle
//  result  | o_valid | i_stall | o_status o_new_handle o_removed_tag o_head_valid
//          |         |         | o_head_tag o_head_time o_entry_count
//
// Each request is first captured and then executed; in the execute cycle every cell of the
// chain compares against it and shifts at once.
// The execute cycle waits while a previous result is still held in the output register under i_stall.
// Reset clears all cell valid bits, the handle pool and the count.
// The output register lets a new request be taken while a result waits under i_stall.
module sorted_event_queue import seq_pkg::*; #(
    parameter int DEPTH = SEQ_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [1:0]          i_req_type,
    input  logic [TAG_W-1:0]    i_event_tag,
    input  logic [TIME_W-1:0]   i_event_time,
    input  logic [HANDLE_W-1:0] i_target_handle,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [1:0]          o_status,
    output logic [HANDLE_W-1:0] o_new_handle,
    output logic [TAG_W-1:0]    o_removed_tag,
    output logic                o_head_valid,
    output logic [TAG_W-1:0]    o_head_tag,
    output logic [TIME_W-1:0]   o_head_time,
    output logic [COUNT_W-1:0]  o_entry_count
);

    t_fsm                    r_state, n_state;
    t_req                    r_req;
    logic [TAG_W-1:0]        r_tag;
    logic [TIME_W-1:0]       r_time;
    logic [HANDLE_W-1:0]     r_target;
    logic [HANDLE_SLOTS-1:0] r_busy, n_busy;
    logic [COUNT_W-1:0]      r_count, n_count;
    logic                    r_ovalid;

    logic                    accept_in;
    logic                    go;
    t_cell_cmd               cmd;
    t_status                 status;
    logic [HANDLE_W-1:0]     free_h;
    logic [HANDLE_W-1:0]     new_h;
    logic [TAG_W-1:0]        removed;
    logic [TAG_W-1:0]        hit_tag;
    logic                    found;

    t_slot                   slots  [DEPTH];
    t_slot                   nexts  [DEPTH];
    t_slot                   lefts  [DEPTH];
    t_slot                   rights [DEPTH];
    logic [DEPTH-1:0]        m_flag, d_flag, hit, left_m, left_d;

    assign accept_in = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FSM_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_stall = 1'b1;
        go      = 1'b0;
        unique case (r_state)
            FSM_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    n_state = FSM_EXEC;
                end
            end
            FSM_EXEC: begin
                if (!r_ovalid || !i_stall) begin
                    go      = 1'b1;
                    n_state = FSM_IDLE;
                end
            end
            default: begin
                n_state = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_req    <= t_req'(i_req_type);
            r_tag    <= i_event_tag;
            r_time   <= i_event_time;
            r_target <= i_target_handle;
        end
    end

    always_comb begin
        free_h = '0;
        for (int i = HANDLE_SLOTS - 1; i >= 0; i--) begin
            if (!r_busy[i]) begin
                free_h = HANDLE_W'(i);
            end
        end
    end

    always_comb begin
        hit_tag = '0;
        for (int i = 0; i < DEPTH; i++) begin
            hit_tag = hit_tag | (slots[i].tag & {TAG_W{hit[i]}});
        end
    end

    assign found = |hit;

    always_comb begin
        cmd.op      = OP_HOLD;
        cmd.ev_time = r_time;
        cmd.tag     = r_tag;
        cmd.handle  = free_h;
        // A pop is a remove of the head's handle, which is unique in the chain.
        cmd.target  = (r_req == REQ_POP) ? slots[0].handle : r_target;
        status      = ST_OK;
        new_h       = '0;
        removed     = '0;
        n_busy      = r_busy;
        n_count     = r_count;
        unique case (r_req)
            REQ_INSERT: begin
                if ((int'(r_count) >= DEPTH) || (&r_busy)) begin
                    status = ST_FULL;
                end else begin
                    cmd.op         = OP_INSERT;
                    new_h          = free_h;
                    n_busy[free_h] = 1'b1;
                    n_count        = r_count + COUNT_W'(1);
                end
            end
            REQ_POP, REQ_REMOVE: begin
                if (!found) begin
                    status = (r_req == REQ_POP) ? ST_EMPTY : ST_NOHANDLE;
                end else begin
                    cmd.op             = OP_REMOVE;
                    removed            = hit_tag;
                    n_busy[cmd.target] = 1'b0;
                    n_count            = r_count - COUNT_W'(1);
                end
            end
            REQ_CLEAR: begin
                cmd.op  = OP_CLEAR;
                n_busy  = '0;
                n_count = '0;
            end
            default: begin
            end
        endcase
        if (!go) begin
            cmd.op  = OP_HOLD;
            n_busy  = r_busy;
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= '0;
            r_count <= '0;
        end else begin
            r_busy  <= n_busy;
            r_count <= n_count;
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            if (g == 0) begin : g_first
                assign lefts[g]  = '0;
                assign left_m[g] = 1'b0;
                assign left_d[g] = 1'b0;
            end else begin : g_mid
                assign lefts[g]  = slots[g-1];
                assign left_m[g] = m_flag[g-1];
                assign left_d[g] = d_flag[g-1];
            end
            if (g == DEPTH - 1) begin : g_last
                assign rights[g] = '0;
            end else begin : g_inner
                assign rights[g] = slots[g+1];
            end

            seq_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_cmd    (cmd),
                .i_left   (lefts[g]),
                .i_left_m (left_m[g]),
                .i_left_d (left_d[g]),
                .i_right  (rights[g]),
                .o_slot   (slots[g]),
                .o_next   (nexts[g]),
                .o_m      (m_flag[g]),
                .o_d      (d_flag[g]),
                .o_hit    (hit[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (go) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            o_status      <= status;
            o_new_handle  <= new_h;
            o_removed_tag <= removed;
            o_head_valid  <= nexts[0].valid;
            o_head_tag    <= nexts[0].valid ? nexts[0].tag : '0;
            o_head_time   <= nexts[0].valid ? nexts[0].ev_time : '0;
            o_entry_count <= n_count;
        end
    end

    assign o_valid = r_ovalid;

endmodule

// ===== hdl/seq_checker.sv =====
// Port-level checker for the sorted event queue and its bind to the top level.
module seq_checker import seq_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_stall,
    input logic                o_valid,
    input logic                i_stall,
    input logic [1:0]          o_status,
    input logic [HANDLE_W-1:0] o_new_handle,
    input logic [TAG_W-1:0]    o_removed_tag,
    input logic                o_head_valid,
    input logic [TAG_W-1:0]    o_head_tag,
    input logic [TIME_W-1:0]   o_head_time,
    input logic [COUNT_W-1:0]  o_entry_count
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_entry_count) && $stable(o_head_tag))
        else $error("Result word changed while stalled.");

    a_head_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_head_valid == (o_entry_count != '0)))
        else $error("Head valid disagrees with entry count.");

    a_empty_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_head_valid |-> (o_head_tag == '0) && (o_head_time == '0))
        else $error("Empty queue reports a nonzero head.");

    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_OK) |-> (o_new_handle == '0) && (o_removed_tag == '0))
        else $error("Failed request reports a handle or a removed tag.");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("A second request was taken before the first executed.");

endmodule

bind sorted_event_queue seq_checker u_seq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_status      (o_status),
    .o_new_handle  (o_new_handle),
    .o_removed_tag (o_removed_tag),
    .o_head_valid  (o_head_valid),
    .o_head_tag    (o_head_tag),
    .o_head_time   (o_head_time),
    .o_entry_count (o_entry_count)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for the sorted event queue: directed table, random traffic, predictor.
`timescale 1ns / 1ps

module testbench;
    import seq_pkg::*;

    localparam int RANDOM_WORDS = 1200;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PRINT_CAP    = 50;
    localparam int PEND_SLOTS   = 8;
    localparam int STIM_SLOTS   = 32;

    typedef struct packed {
        t_status             status;
        logic [HANDLE_W-1:0] new_handle;
        logic [TAG_W-1:0]    removed_tag;
        logic                head_valid;
        logic [TAG_W-1:0]    head_tag;
        logic [TIME_W-1:0]   head_time;
        logic [COUNT_W-1:0]  entry_count;
    } t_result;

    typedef struct {
        t_req                req;
        logic [TAG_W-1:0]    tag;
        logic [TIME_W-1:0]   ev_time;
        logic [HANDLE_W-1:0] target;
        bit                  typed;
        t_result             want;
    } t_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic [1:0]          i_req_type = 2'd0;
    logic [TAG_W-1:0]    i_event_tag = '0;
    logic [TIME_W-1:0]   i_event_time = '0;
    logic [HANDLE_W-1:0] i_target_handle = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic [1:0]          o_status;
    logic [HANDLE_W-1:0] o_new_handle;
    logic [TAG_W-1:0]    o_removed_tag;
    logic                o_head_valid;
    logic [TAG_W-1:0]    o_head_tag;
    logic [TIME_W-1:0]   o_head_time;
    logic [COUNT_W-1:0]  o_entry_count;

    sorted_event_queue uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_req_type      (i_req_type),
        .i_event_tag     (i_event_tag),
        .i_event_time    (i_event_time),
        .i_target_handle (i_target_handle),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_new_handle    (o_new_handle),
        .o_removed_tag   (o_removed_tag),
        .o_head_valid    (o_head_valid),
        .o_head_tag      (o_head_tag),
        .o_head_time     (o_head_time),
        .o_entry_count   (o_entry_count)
    );

    always #4 i_clk = ~i_clk;

    // Shadow copy of the queue contents, kept sorted with the head in entry 0.
    logic [TIME_W-1:0]   shadow_time [SEQ_DEPTH];
    logic [TAG_W-1:0]    shadow_tag [SEQ_DEPTH];
    logic [HANDLE_W-1:0] shadow_handle [SEQ_DEPTH];
    logic [HANDLE_SLOTS-1:0] handles_used = '0;
    int                  shadow_len = 0;

    t_result pending_results [PEND_SLOTS];
    int      pend_wr = 0;
    int      pend_rd = 0;
    t_row    stim_rows [STIM_SLOTS];
    int      stim_count = 0;
    int      mismatch_count = 0;
    int unsigned cycle_count = 0;

    task automatic report(input string msg);
        if (mismatch_count < PRINT_CAP) begin
            $display("ERROR @%0t: %s", $realtime, msg);
        end
        mismatch_count++;
    endtask

    function automatic t_result predict_queue_op(input t_req req, input logic [TAG_W-1:0] tag,
                                                 input logic [TIME_W-1:0] ev_time,
                                                 input logic [HANDLE_W-1:0] target);
        t_result r;
        int      i;
        int      free_h;
        int      pos;
        int      drop_pos;
        r = '0;
        r.status = ST_OK;
        drop_pos = -1;
        case (req)
            REQ_INSERT: begin
                free_h = HANDLE_SLOTS;
                for (i = HANDLE_SLOTS - 1; i >= 0; i--) begin
                    if (!handles_used[i]) free_h = i;
                end
                if (shadow_len >= SEQ_DEPTH || free_h >= HANDLE_SLOTS) begin
                    r.status = ST_FULL;
                end else begin
                    pos = shadow_len;
                    for (i = shadow_len - 1; i >= 0; i--) begin
                        if (shadow_time[i] > ev_time) pos = i;
                    end
                    for (i = shadow_len; i > pos; i--) begin
                        shadow_time[i]   = shadow_time[i-1];
                        shadow_tag[i]    = shadow_tag[i-1];
                        shadow_handle[i] = shadow_handle[i-1];
                    end
                    shadow_time[pos]   = ev_time;
                    shadow_tag[pos]    = tag;
                    shadow_handle[pos] = HANDLE_W'(free_h);
                    shadow_len++;
                    handles_used[free_h] = 1'b1;
                    r.new_handle = HANDLE_W'(free_h);
                end
            end
            REQ_POP: begin
                if (shadow_len == 0) r.status = ST_EMPTY;
                else drop_pos = 0;
            end
            REQ_REMOVE: begin
                for (i = shadow_len - 1; i >= 0; i--) begin
                    if (shadow_handle[i] == target) drop_pos = i;
                end
                if (drop_pos < 0) r.status = ST_NOHANDLE;
            end
            default: begin
                shadow_len = 0;
                handles_used = '0;
            end
        endcase
        if (drop_pos >= 0) begin
            r.removed_tag = shadow_tag[drop_pos];
            handles_used[shadow_handle[drop_pos]] = 1'b0;
            for (i = drop_pos; i + 1 < shadow_len; i++) begin
                shadow_time[i]   = shadow_time[i+1];
                shadow_tag[i]    = shadow_tag[i+1];
                shadow_handle[i] = shadow_handle[i+1];
            end
            shadow_len--;
        end
        r.head_valid  = (shadow_len != 0);
        r.head_tag    = (shadow_len != 0) ? shadow_tag[0] : '0;
        r.head_time   = (shadow_len != 0) ? shadow_time[0] : '0;
        r.entry_count = COUNT_W'(shadow_len);
        return r;
    endfunction

    function automatic int unsigned idle_len();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 60) return 0;
        if (roll < 94) return $urandom_range(1, 3);
        if (roll < 99) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_result result_of(input t_status st, input logic [HANDLE_W-1:0] nh,
                                          input logic [TAG_W-1:0] rtag, input logic hv,
                                          input logic [TAG_W-1:0] htag,
                                          input logic [TIME_W-1:0] htime,
                                          input logic [COUNT_W-1:0] cnt);
        t_result r;
        r.status      = st;
        r.new_handle  = nh;
        r.removed_tag = rtag;
        r.head_valid  = hv;
        r.head_tag    = htag;
        r.head_time   = htime;
        r.entry_count = cnt;
        return r;
    endfunction

    function automatic t_row stim_row(input t_req req, input logic [TAG_W-1:0] tag,
                                      input logic [TIME_W-1:0] ev_time,
                                      input logic [HANDLE_W-1:0] target,
                                      input bit typed, input t_result want);
        t_row row;
        row.req     = req;
        row.tag     = tag;
        row.ev_time = ev_time;
        row.target  = target;
        row.typed   = typed;
        row.want    = want;
        return row;
    endfunction

    task automatic add_stim(input t_row row);
        stim_rows[stim_count] = row;
        stim_count++;
    endtask

    // Offers one request word and records its expected result once it is taken.
    task automatic offer_word(input t_req req, input logic [TAG_W-1:0] tag,
                              input logic [TIME_W-1:0] ev_time,
                              input logic [HANDLE_W-1:0] target,
                              input bit typed, input t_result want);
        t_result predicted;
        i_valid         <= 1'b1;
        i_req_type      <= req;
        i_event_tag     <= tag;
        i_event_time    <= ev_time;
        i_target_handle <= target;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predicted = predict_queue_op(req, tag, ev_time, target);
        pending_results[pend_wr % PEND_SLOTS] = typed ? want : predicted;
        pend_wr++;
    endtask

    task automatic sender_gap(input int unsigned cycles);
        if (cycles != 0) begin
            i_valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin : request_source
        t_req                req;
        logic [TAG_W-1:0]    tag;
        logic [TIME_W-1:0]   ev_time;
        logic [HANDLE_W-1:0] target;
        int unsigned         roll;
        int unsigned         ins_pct;
        int unsigned         pop_pct;
        bit                  calm;
        int                  k;
        calm = 1'b0;
        ins_pct = 50;
        pop_pct = 25;

        add_stim(stim_row(REQ_POP, '0, '0, '0, 1'b1,
                          result_of(ST_EMPTY, '0, '0, 1'b0, '0, '0, '0)));
        add_stim(stim_row(REQ_REMOVE, '0, '0, 4'hF, 1'b1,
                          result_of(ST_NOHANDLE, '0, '0, 1'b0, '0, '0, '0)));
        add_stim(stim_row(REQ_CLEAR, '0, '0, '0, 1'b1,
                          result_of(ST_OK, '0, '0, 1'b0, '0, '0, '0)));
        add_stim(stim_row(REQ_INSERT, '1, '1, 4'hF, 1'b1,
                          result_of(ST_OK, 4'd0, '0, 1'b1, '1, '1, 5'd1)));
        add_stim(stim_row(REQ_INSERT, '0, '0, '0, 1'b1,
                          result_of(ST_OK, 4'd1, '0, 1'b1, '0, '0, 5'd2)));
        add_stim(stim_row(REQ_INSERT, 32'h5555_5555, 64'd0, '0, 1'b0, '0));
        add_stim(stim_row(REQ_INSERT, 32'hAAAA_AAAA, 64'hFFFF_FFFF_FFFF_FFFE, '0, 1'b0, '0));
        add_stim(stim_row(REQ_INSERT, 32'h33, '1, '0, 1'b0, '0));
        add_stim(stim_row(REQ_INSERT, 32'h44, 64'h8000_0000_0000_0000, '0, 1'b0, '0));
        add_stim(stim_row(REQ_INSERT, 32'h55, 64'h5555_5555_5555_5555, '0, 1'b0, '0));
        add_stim(stim_row(REQ_INSERT, 32'h66, 64'hAAAA_AAAA_AAAA_AAAA, '0, 1'b0, '0));
        add_stim(stim_row(REQ_INSERT, 32'h77, 64'd1, '0, 1'b0, '0));
        add_stim(stim_row(REQ_INSERT, 32'h88, 64'd1000, '0, 1'b0, '0));
        add_stim(stim_row(REQ_INSERT, 32'h99, 64'd1000, '0, 1'b0, '0));
        add_stim(stim_row(REQ_INSERT, 32'hAA, 64'h0000_0001_0000_0000, '0, 1'b0, '0));
        add_stim(stim_row(REQ_INSERT, 32'hBB, 64'h0000_0000_FFFF_FFFF, '0, 1'b0, '0));
        add_stim(stim_row(REQ_INSERT, 32'hCC, 64'd500, '0, 1'b0, '0));
        add_stim(stim_row(REQ_INSERT, 32'hDD, 64'd1000, '0, 1'b0, '0));
        add_stim(stim_row(REQ_INSERT, 32'hEE, 64'h7FFF_FFFF_FFFF_FFFF, '0, 1'b0, '0));
        add_stim(stim_row(REQ_INSERT, 32'hFF, 64'd3, '0, 1'b1,
                          result_of(ST_FULL, '0, '0, 1'b1, '0, '0, 5'd16)));
        add_stim(stim_row(REQ_REMOVE, '0, '0, 4'd15, 1'b0, '0));
        add_stim(stim_row(REQ_REMOVE, '0, '0, 4'd15, 1'b1,
                          result_of(ST_NOHANDLE, '0, '0, 1'b1, '0, '0, 5'd15)));
        add_stim(stim_row(REQ_POP, '0, '0, '0, 1'b0, '0));
        add_stim(stim_row(REQ_INSERT, 32'h12, 64'd1000, '0, 1'b0, '0));
        add_stim(stim_row(REQ_CLEAR, '0, '0, '0, 1'b1,
                          result_of(ST_OK, '0, '0, 1'b0, '0, '0, '0)));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < stim_count; k++) begin
            offer_word(stim_rows[k].req, stim_rows[k].tag, stim_rows[k].ev_time,
                       stim_rows[k].target, stim_rows[k].typed, stim_rows[k].want);
            sender_gap(idle_len());
        end

        for (k = 0; k < RANDOM_WORDS; k++) begin
            if (k % 60 == 0) begin
                case ($urandom_range(2))
                    0: begin ins_pct = 70; pop_pct = 15; end
                    1: begin ins_pct = 25; pop_pct = 40; end
                    default: begin ins_pct = 50; pop_pct = 25; end
                endcase
            end
            if (k % 100 == 0) calm = ($urandom_range(3) == 0);
            // After 700 random words, wait until every outstanding result has come back before going on.
            if (k == 700) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (pend_wr != pend_rd) @(posedge i_clk);
            end

            tag = $urandom;
            roll = $urandom_range(99);
            if (roll < 30) ev_time = TIME_W'($urandom_range(7));
            else if (roll < 35) ev_time = '1;
            else if (roll < 40) ev_time = {32'hFFFF_FFFF, 32'($urandom)};
            else ev_time = {32'($urandom), 32'($urandom)};
            target = HANDLE_W'($urandom_range(15));

            if ($urandom_range(9) == 0) begin
                req = t_req'($urandom_range(3));
            end else begin
                roll = $urandom_range(99);
                if (roll < ins_pct) req = REQ_INSERT;
                else if (roll < ins_pct + pop_pct) req = REQ_POP;
                else if (roll < 98) req = REQ_REMOVE;
                else req = REQ_CLEAR;
                // Most removes name a handle that is live in the queue.
                if (req == REQ_REMOVE && handles_used != '0 && $urandom_range(4) != 0) begin
                    while (!handles_used[target]) target = target + HANDLE_W'(1);
                end
            end

            offer_word(req, tag, ev_time, target, 1'b0, '0);
            sender_gap(calm ? 0 : idle_len());
        end
        i_valid <= 1'b0;

        while (pend_wr != pend_rd) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin : result_sink
        t_result     want;
        int unsigned stall_left;
        int unsigned hold_left;
        int unsigned results_seen;
        bit          held_long;
        bit          calm;
        stall_left = 0;
        hold_left = 0;
        results_seen = 0;
        held_long = 1'b0;
        calm = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                results_seen++;
                if (pend_wr == pend_rd) begin
                    report("result word arrived with no request outstanding");
                end else begin
                    want = pending_results[pend_rd % PEND_SLOTS];
                    pend_rd++;
                    if (o_status !== want.status)
                        report($sformatf("status got %0d want %0d", o_status, want.status));
                    if (o_new_handle !== want.new_handle)
                        report($sformatf("new_handle got %0d want %0d",
                                         o_new_handle, want.new_handle));
                    if (o_removed_tag !== want.removed_tag)
                        report($sformatf("removed_tag got %h want %h",
                                         o_removed_tag, want.removed_tag));
                    if (o_head_valid !== want.head_valid)
                        report($sformatf("head_valid got %b want %b",
                                         o_head_valid, want.head_valid));
                    if (o_head_tag !== want.head_tag)
                        report($sformatf("head_tag got %h want %h", o_head_tag, want.head_tag));
                    if (o_head_time !== want.head_time)
                        report($sformatf("head_time got %h want %h",
                                         o_head_time, want.head_time));
                    if (o_entry_count !== want.entry_count)
                        report($sformatf("entry_count got %0d want %0d",
                                         o_entry_count, want.entry_count));
                end
            end

            if ($urandom_range(199) == 0) calm = !calm;
            // Once, hold the output off long enough for the queue to back up its input.
            if (!held_long && results_seen >= 400) begin
                held_long = 1'b1;
                hold_left = 300;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                if (stall_left == 0 && !calm) stall_left = idle_len();
                i_stall <= (stall_left != 0);
                if (stall_left != 0) stall_left--;
            end
        end
    end

endmodule

// ===== filelist.f =====
hdl/seq_pkg.sv
hdl/seq_cell.sv
hdl/sorted_event_queue.sv
hdl/seq_checker.sv
tb/testbench.sv
